FILE: rtl/stepper_halfstep_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// stepper half-step sequencer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALFSTEP_SEQUENCER_CORE_DEFINES_SVH
`define STEPPER_HALFSTEP_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shs assertion failed");

`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shs assertion failed");

`else

`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// widths, constants and codes of the stepper half-step sequencer
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int STEPS_PER_TURN = 4096;
  localparam int POS_W          = $clog2(STEPS_PER_TURN);
  localparam int CNT_W          = POS_W + 1;

  localparam int ACTION_W = 2;
  localparam int ANGLE_W  = 9;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int DEG_W    = 9;
  localparam int PAT_W    = COIL_W * (2 ** PHASE_W);

  localparam int DEG_PER_TURN  = 360;
  localparam int HALF_TURN_DEG = 180;
  localparam int MAX_ANGLE     = 360;

  localparam logic [PAT_W-1:0] PATTERNS_RESET = 32'h98C4_6231;

  // round(angle * steps / 360) through a reciprocal of 360
  localparam int RND_W       = ANGLE_W + POS_W;
  localparam int RECIP_SHIFT = RND_W + 9;
  localparam longint unsigned RECIP_MULT =
    ((64'd1 << RECIP_SHIFT) + DEG_PER_TURN - 1) / DEG_PER_TURN;
  localparam int RECIP_W = $clog2(RECIP_MULT + 1);
  localparam int PROD_W  = RND_W + RECIP_W;

  localparam int DEG_PROD_W = POS_W + DEG_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ROTATE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_RESET  = 2'd2
  } action_e;

endpackage

FILE: rtl/shs_in_if.sv
// ----------------------------------------------------------------------------
// shs_in_if
// command beat channel: action and relative angle
// ----------------------------------------------------------------------------
interface shs_in_if
  import shs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ANGLE_W-1:0]  angle_degrees;

  modport source (output valid, output action, output angle_degrees, input ready);
  modport sink   (input valid, input action, input angle_degrees, output ready);
endinterface

FILE: rtl/shs_out_if.sv
// ----------------------------------------------------------------------------
// shs_out_if
// result beat channel: coil drive, status flags and position
// ----------------------------------------------------------------------------
interface shs_out_if
  import shs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_pattern;
  logic              stepped;
  logic              busy_res;
  logic              rejected;
  logic [DEG_W-1:0]  position_degrees;

  modport source (
    output valid, output coil_pattern, output stepped, output busy_res,
    output rejected, output position_degrees, input ready
  );
  modport sink (
    input valid, input coil_pattern, input stepped, input busy_res,
    input rejected, input position_degrees, output ready
  );
endinterface

FILE: rtl/stepper_halfstep_sequencer_core.sv
// ----------------------------------------------------------------------------
// stepper_halfstep_sequencer_core
// half-step coil sequencer for a unipolar stepper with position in degrees
//
// path: command beat into the input register, then the result register
// throughput: one beat per cycle unless out_o stalls; step count multiply
//   before the input register, state update before the result register
// reset: asynchronous, position, step count, phase and coils cleared,
//   phase patterns back to their default table
// ----------------------------------------------------------------------------
`include "stepper_halfstep_sequencer_core_defines.svh"

module stepper_halfstep_sequencer_core
  import shs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PAT_W-1:0] cfg_wdata_i,
  shs_in_if.sink           in_i,
  shs_out_if.source        out_o
);

  logic [PAT_W-1:0] patterns_q;

  // input register
  logic                s1_valid_q;
  logic [ACTION_W-1:0] s1_action_q;
  logic                s1_angle_ok_q;
  logic [CNT_W-1:0]    s1_steps_q;

  logic [RND_W-1:0]  round_num;
  logic [PROD_W-1:0] round_prod;
  logic              s2_load;

  // sequencer state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [COIL_W-1:0]  coil_q, coil_d;
  logic [CNT_W-1:0]   pos_inc;
  logic               stepped_d;
  logic               rejected_d;
  logic [DEG_PROD_W-1:0] deg_prod;

  // result register
  logic              out_valid_q;
  logic [COIL_W-1:0] res_coil_q;
  logic              res_stepped_q;
  logic              res_busy_q;
  logic              res_rejected_q;
  logic [DEG_W-1:0]  res_deg_q;

  assign s2_load   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s2_load;

  always_comb begin
    round_num  = {in_i.angle_degrees, {POS_W{1'b0}}} + RND_W'(HALF_TURN_DEG);
    round_prod = PROD_W'(round_num) * PROD_W'(RECIP_MULT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patterns_q <= PATTERNS_RESET;
    end else if (cfg_we_i) begin
      patterns_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_action_q   <= in_i.action;
      s1_angle_ok_q <= (in_i.angle_degrees <= ANGLE_W'(MAX_ANGLE));
      s1_steps_q    <= round_prod[RECIP_SHIFT +: CNT_W];
    end
  end

  always_comb begin
    pos_d      = pos_q;
    steps_d    = steps_q;
    phase_d    = phase_q;
    coil_d     = coil_q;
    stepped_d  = 1'b0;
    rejected_d = 1'b0;
    pos_inc    = {1'b0, pos_q} + CNT_W'(1);
    unique case (action_e'(s1_action_q))
      ACT_ROTATE: begin
        if (!s1_angle_ok_q || (steps_q != '0)) begin
          rejected_d = 1'b1;
        end else begin
          steps_d = s1_steps_q;
          phase_d = '0;
        end
      end
      ACT_TICK: begin
        if (steps_q != '0) begin
          coil_d    = patterns_q[{phase_q, 2'b00} +: COIL_W];
          phase_d   = phase_q + PHASE_W'(1);
          pos_d     = (pos_inc == CNT_W'(STEPS_PER_TURN)) ? '0 : pos_inc[POS_W-1:0];
          steps_d   = steps_q - CNT_W'(1);
          stepped_d = 1'b1;
        end
      end
      ACT_RESET: begin
        coil_d  = '0;
        pos_d   = '0;
        steps_d = '0;
      end
      default: begin
      end
    endcase
    // steps per turn is a power of two, so the scale down is a shift
    deg_prod = DEG_PROD_W'(pos_d) * DEG_PROD_W'(DEG_PER_TURN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      steps_q <= '0;
      phase_q <= '0;
      coil_q  <= '0;
    end else if (s2_load) begin
      pos_q   <= pos_d;
      steps_q <= steps_d;
      phase_q <= phase_d;
      coil_q  <= coil_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_coil_q     <= coil_d;
      res_stepped_q  <= stepped_d;
      res_busy_q     <= (steps_d != '0);
      res_rejected_q <= rejected_d;
      res_deg_q      <= deg_prod[POS_W +: DEG_W];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.coil_pattern     = res_coil_q;
  assign out_o.stepped          = res_stepped_q;
  assign out_o.busy_res         = res_busy_q;
  assign out_o.rejected         = res_rejected_q;
  assign out_o.position_degrees = res_deg_q;

  `SHS_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni,
    s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready)
  `SHS_ASSERT_IMPL(a_step_not_rejected, clk_i, rst_ni,
    out_valid_q && res_stepped_q, !res_rejected_q)
  `SHS_ASSERT_IMPL(a_position_in_turn, clk_i, rst_ni,
    out_valid_q, res_deg_q < DEG_W'(DEG_PER_TURN))
  `SHS_ASSERT_NEXT(a_tick_counts_down, clk_i, rst_ni,
    s2_load && (s1_action_q == ACT_TICK) && (steps_q != '0),
    steps_q == $past(steps_q) - CNT_W'(1))

endmodule
